### rtl/svc_pkg.sv
// shared types and constants for the shifted vigenere cipher
// no dependencies; imported by every module of the block
package svc_pkg;

    localparam int unsigned LETTER_W  = 5;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned KEY_POS_W = 4;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [LETTER_W-1:0]  letter_t;
    typedef logic [CHAR_W-1:0]    char_t;
    typedef logic [KEY_POS_W-1:0] key_pos_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam letter_t LETTER_COUNT = 5'd26;

    localparam char_t CHAR_UA    = 8'h41;
    localparam char_t CHAR_UZ    = 8'h5a;
    localparam char_t CHAR_LA    = 8'h61;
    localparam char_t CHAR_LZ    = 8'h7a;
    localparam char_t CHAR_SPACE = 8'h20;
    localparam char_t CHAR_NONE  = 8'h00;

    // configuration register indexes
    localparam cfg_idx_t CFG_DIRECTION    = 2'd0;
    localparam cfg_idx_t CFG_CAESAR_SHIFT = 2'd1;
    localparam cfg_idx_t CFG_KEY_WORD     = 2'd2;
    localparam cfg_idx_t CFG_KEY_LENGTH   = 2'd3;

    typedef enum logic [1:0] {
        CLS_LETTER = 2'd0,
        CLS_SPACE  = 2'd1,
        CLS_BAD    = 2'd2
    } char_cls_t;

    // item held between the input stage and the output stage
    typedef struct packed {
        char_cls_t cls;
        letter_t   letter;
        letter_t   key_letter;
        logic      last;
    } stage_item_t;

endpackage

### rtl/svc_in_stage.sv
// input stage: character classification, key position counter, key letter pick
// depends on svc_pkg
module svc_in_stage #(
    parameter int MAX_KEY_LETTERS = 12
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  svc_pkg::char_t                               char_in,
    input  logic                                         last_in,
    input  logic [svc_pkg::LETTER_W*MAX_KEY_LETTERS-1:0] key_word,
    input  svc_pkg::key_pos_t                            key_length,
    input  logic                                         out_ready,
    output logic                                         item_valid,
    output svc_pkg::stage_item_t                         item
);
    import svc_pkg::*;

    localparam key_pos_t MaxLen = KEY_POS_W'(MAX_KEY_LETTERS);

    logic        valid_reg, valid_next;
    stage_item_t item_reg, item_next;
    key_pos_t    key_pos_reg, key_pos_next;
    key_pos_t    used_len, idx, idx_inc;
    logic        accept;

    assign in_ready   = !valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        // clamp key length to 1..max
        if (key_length == '0) begin
            used_len = KEY_POS_W'(1);
        end else if (key_length > MaxLen) begin
            used_len = MaxLen;
        end else begin
            used_len = key_length;
        end
        idx     = (key_pos_reg < used_len) ? key_pos_reg : '0;
        idx_inc = idx + KEY_POS_W'(1);

        item_next            = item_reg;
        item_next.last       = last_in;
        item_next.key_letter = '0;
        for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
            if (idx == KEY_POS_W'(i)) begin
                item_next.key_letter = key_word[LETTER_W*i +: LETTER_W];
            end
        end

        if (char_in inside {[CHAR_UA:CHAR_UZ]}) begin
            item_next.cls    = CLS_LETTER;
            item_next.letter = LETTER_W'(char_in - CHAR_UA);
        end else if (char_in inside {[CHAR_LA:CHAR_LZ]}) begin
            item_next.cls    = CLS_LETTER;
            item_next.letter = LETTER_W'(char_in - CHAR_LA);
        end else if (char_in == CHAR_SPACE) begin
            item_next.cls    = CLS_SPACE;
            item_next.letter = '0;
        end else begin
            item_next.cls    = CLS_BAD;
            item_next.letter = '0;
        end

        // only letters advance the key; last item rewinds it
        key_pos_next = key_pos_reg;
        if (accept) begin
            if (last_in) begin
                key_pos_next = '0;
            end else if (item_next.cls == CLS_LETTER) begin
                key_pos_next = (idx_inc >= used_len) ? '0 : idx_inc;
            end
        end

        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            key_pos_reg <= '0;
        end else begin
            valid_reg   <= valid_next;
            key_pos_reg <= key_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

### rtl/svc_out_stage.sv
// output stage: mod-26 shift of the letter and the result register
// depends on svc_pkg
module svc_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  svc_pkg::stage_item_t item,
    output logic                 out_ready,
    input  logic                 direction,
    input  svc_pkg::letter_t     caesar_shift,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output svc_pkg::char_t       char_out,
    output logic                 bad_char,
    output logic                 last_out
);
    import svc_pkg::*;

    // one conditional subtract brings a value below 52 into 0..25
    function automatic letter_t fold26(input logic [LETTER_W:0] v);
        logic [LETTER_W:0] r;
        r = (v >= {1'b0, LETTER_COUNT}) ? v - {1'b0, LETTER_COUNT} : v;
        return r[LETTER_W-1:0];
    endfunction

    logic              valid_reg, valid_next;
    char_t             char_reg, char_next;
    logic              bad_reg, bad_next;
    logic              last_reg;
    letter_t           caesar_m, key_m, shift, new_pos;
    logic [LETTER_W:0] sum;

    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign char_out  = char_reg;
    assign bad_char  = bad_reg;
    assign last_out  = last_reg;

    always_comb begin
        caesar_m = fold26({1'b0, caesar_shift});
        key_m    = fold26({1'b0, item.key_letter});
        shift    = fold26({1'b0, caesar_m} + {1'b0, key_m});
        if (direction) begin
            sum = {1'b0, item.letter} + {1'b0, LETTER_COUNT} - {1'b0, shift};
        end else begin
            sum = {1'b0, item.letter} + {1'b0, shift};
        end
        new_pos = fold26(sum);

        case (item.cls)
            CLS_LETTER: begin
                char_next = CHAR_UA + CHAR_W'(new_pos);
                bad_next  = 1'b0;
            end
            CLS_SPACE: begin
                char_next = CHAR_SPACE;
                bad_next  = 1'b0;
            end
            default: begin
                char_next = CHAR_NONE;
                bad_next  = 1'b1;
            end
        endcase

        valid_next = out_ready ? item_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && item_valid) begin
            char_reg <= char_next;
            bad_reg  <= bad_next;
            last_reg <= item.last;
        end
    end

endmodule

### rtl/shifted_vigenere_cipher_top.sv
// top level of the shifted vigenere cipher: configuration registers and stages
// depends on svc_pkg, svc_in_stage, svc_out_stage
//
//   channel   direction  tdata                tuser      tlast
//   s_        in         [7:0] char_in        -          last_in
//   m_        out        [7:0] char_out       bad_char   last_out
//   cfg_      in         cfg_wdata, index 0 direction, 1 caesar_shift,
//                        2 key_word, 3 key_length (write only)
//
// one item per clock sustained while m_tready stays high; each item passes
// through the input register and then the result register on its way out
// the key position counter computes its next value combinationally from its
// own register, so letters follow each other with no gap
// synchronous active-low reset clears both stages and the key position, and
// sets the configuration registers to defaults (shift 1, length 7); no clearing pass
// a stalled result holds in the output register while the input register
// still takes one more item
module shifted_vigenere_cipher_top #(
    parameter int MAX_KEY_LETTERS = 12
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // input items
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [7:0]                                   s_tdata,  // [7:0] char_in
    input  logic                                         s_tlast,  // last_in
    // result items
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [7:0]                                   m_tdata,  // [7:0] char_out
    output logic                                         m_tuser,  // [0] bad_char
    output logic                                         m_tlast,  // last_out
    // configuration writes
    input  logic                                         cfg_we,
    input  svc_pkg::cfg_idx_t                            cfg_index,
    input  logic [svc_pkg::LETTER_W*MAX_KEY_LETTERS-1:0] cfg_wdata
);
    import svc_pkg::*;

    localparam int KeyW = LETTER_W * MAX_KEY_LETTERS;

    // configuration registers
    logic              direction_reg;
    letter_t           caesar_shift_reg;
    logic [KeyW-1:0]   key_word_reg;
    key_pos_t          key_length_reg;

    // between the stages
    logic              item_valid;
    logic              out_ready;
    stage_item_t       item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg    <= 1'b0;
            caesar_shift_reg <= LETTER_W'(1);
            key_word_reg     <= '0;
            key_length_reg   <= KEY_POS_W'(7);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DIRECTION:    direction_reg    <= cfg_wdata[0];
                CFG_CAESAR_SHIFT: caesar_shift_reg <= cfg_wdata[LETTER_W-1:0];
                CFG_KEY_WORD:     key_word_reg     <= cfg_wdata;
                CFG_KEY_LENGTH:   key_length_reg   <= cfg_wdata[KEY_POS_W-1:0];
                default: ;
            endcase
        end
    end

    // classify, track key position, pick the key letter
    svc_in_stage #(
        .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
    ) u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .char_in    (s_tdata),
        .last_in    (s_tlast),
        .key_word   (key_word_reg),
        .key_length (key_length_reg),
        .out_ready  (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    // mod-26 shift and result register
    svc_out_stage u_out_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .out_ready    (out_ready),
        .direction    (direction_reg),
        .caesar_shift (caesar_shift_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .char_out     (m_tdata),
        .bad_char     (m_tuser),
        .last_out     (m_tlast)
    );

endmodule

### rtl/svc_checker.sv
// port-level checks for the shifted vigenere cipher top level
// depends on svc_pkg; bound to shifted_vigenere_cipher_top
module svc_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);
    import svc_pkg::*;

    // a stalled result item keeps its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result item changed while stalled");

    // an error item carries a zero character
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == CHAR_NONE)
        else $error("error item with nonzero character");

    // a good item is an upper-case letter or a space
    a_good_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == CHAR_SPACE
            || (m_tdata >= CHAR_UA && m_tdata <= CHAR_UZ))
        else $error("good item outside upper-case letters and space");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind shifted_vigenere_cipher_top svc_port_checks u_svc_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
